>>> hdl/bmf_pkg.sv
// Shared constants for the binary morphology filter: register map, field widths,
// reset values and mode codes. No dependencies.
`default_nettype none

package bmf_pkg;

    // Field and register widths
    localparam int FW_W    = 11;   // frame_width register
    localparam int FH_W    = 12;   // frame_height register, also the output row counter
    localparam int MASK_W  = 25;   // structuring element register
    localparam int DATA_W  = 32;   // configuration data bus
    localparam int PADDR_W = 4;    // four 32-bit registers

    // Defaults for the top level parameters
    localparam int MAX_WIDTH_DEF = 1024;
    localparam int RADIUS_DEF    = 2;

    // Register indexes (byte address = 4 * index)
    localparam logic [1:0] REG_MODE   = 2'd0;
    localparam logic [1:0] REG_MASK   = 2'd1;
    localparam logic [1:0] REG_WIDTH  = 2'd2;
    localparam logic [1:0] REG_HEIGHT = 2'd3;

    // Mode codes
    localparam logic MODE_ERODE  = 1'b0;
    localparam logic MODE_DILATE = 1'b1;

    // Reset values: 3x3 center square, VGA frame
    localparam logic [MASK_W-1:0] MASK_RESET   = 25'h0739C0;
    localparam logic [FW_W-1:0]   WIDTH_RESET  = 11'd640;
    localparam logic [FH_W-1:0]   HEIGHT_RESET = 12'd480;

endpackage

`default_nettype wire

>>> hdl/binary_morphology_filter.sv
// Streaming binary erosion / dilation with a configurable structuring element.
// Depends on bmf_pkg, bmf_line_store and bmf_kernel.
//
// Usage:
//  - Request channel (req_valid/req_ready, command, pixel_in): one pixel per request
//    in raster order; command=1 is a drain step that acts as a background pixel.
//    After the last pixel of a frame send RADIUS*width + RADIUS drain requests.
//  - Result channel (res_valid/res_ready, pixel_out, last_of_frame): one filtered
//    pixel per request once the stream is RADIUS rows plus RADIUS pixels ahead;
//    last_of_frame marks the final pixel, after which all positions restart at zero.
//  - APB port: mode (0x0), se_mask (0x4), frame_width (0x8), frame_height (0xC).
//    Write only while the stream is idle; values take effect at once.
//  - Throughput: one request per cycle unless back-pressure or the reset sweep holds it.
//    The column memory is read at acceptance and written back as stage 1 advances;
//    a same-column access on the next request is forwarded, so no stall results.
//  - Result path: the request that completes a window passes stage 1 and the output
//    register before its result appears on the result port.
//  - Reset: all MAX_WIDTH entries of the column memory are swept to zero with
//    req_ready low; configuration writes are taken meanwhile.
//  - Receiver stall: the output register holds the result; the next request that
//    yields a result is held in stage 1, then req_ready drops until res_ready returns.
`default_nettype none

module binary_morphology_filter #(
    parameter int MAX_WIDTH = bmf_pkg::MAX_WIDTH_DEF,
    parameter int RADIUS    = bmf_pkg::RADIUS_DEF
) (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    // configuration
    input  wire logic                        psel,
    input  wire logic                        penable,
    input  wire logic                        pwrite,
    input  wire logic [bmf_pkg::PADDR_W-1:0] paddr,
    input  wire logic [bmf_pkg::DATA_W-1:0]  pwdata,
    output logic      [bmf_pkg::DATA_W-1:0]  prdata,
    output logic                             pready,
    // requests
    input  wire logic                        req_valid,
    output logic                             req_ready,
    input  wire logic                        command,
    input  wire logic                        pixel_in,
    // results
    output logic                             res_valid,
    input  wire logic                        res_ready,
    output logic                             pixel_out,
    output logic                             last_of_frame
);

    localparam int FW_W  = bmf_pkg::FW_W;
    localparam int FH_W  = bmf_pkg::FH_W;
    localparam int CW    = $clog2(MAX_WIDTH);
    localparam int SIDE  = 2 * RADIUS + 1;
    localparam int LSW   = 2 * RADIUS;
    localparam int IRW   = FH_W + 1;
    localparam int PW    = ((FW_W > CW) ? FW_W : CW) + 4;
    localparam int RIW   = $clog2(2 * RADIUS);
    localparam int W_MAX = (1 << FW_W) - 1;
    localparam int W_CAP = (MAX_WIDTH > W_MAX) ? W_MAX : MAX_WIDTH;

    // ------------------------------------------------------------------ registers
    logic                       mode_reg;
    logic [bmf_pkg::MASK_W-1:0] se_mask_reg;
    logic [FW_W-1:0]            frame_width_reg;
    logic [FH_W-1:0]            frame_height_reg;
    logic                       cfg_wr;

    assign cfg_wr = psel & penable & pwrite & pready;
    assign pready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg         <= bmf_pkg::MODE_ERODE;
            se_mask_reg      <= bmf_pkg::MASK_RESET;
            frame_width_reg  <= bmf_pkg::WIDTH_RESET;
            frame_height_reg <= bmf_pkg::HEIGHT_RESET;
        end
        else if (cfg_wr)
        begin
            case (paddr[3:2])
                bmf_pkg::REG_MODE:   mode_reg         <= pwdata[0];
                bmf_pkg::REG_MASK:   se_mask_reg      <= pwdata[bmf_pkg::MASK_W-1:0];
                bmf_pkg::REG_WIDTH:  frame_width_reg  <= pwdata[FW_W-1:0];
                bmf_pkg::REG_HEIGHT: frame_height_reg <= pwdata[FH_W-1:0];
                default:             mode_reg         <= mode_reg;
            endcase
        end
    end

    always_comb
    begin
        case (paddr[3:2])
            bmf_pkg::REG_MODE:   prdata = bmf_pkg::DATA_W'(mode_reg);
            bmf_pkg::REG_MASK:   prdata = bmf_pkg::DATA_W'(se_mask_reg);
            bmf_pkg::REG_WIDTH:  prdata = bmf_pkg::DATA_W'(frame_width_reg);
            bmf_pkg::REG_HEIGHT: prdata = bmf_pkg::DATA_W'(frame_height_reg);
            default:             prdata = '0;
        endcase
    end

    // effective frame size: zero acts as one, width capped at the memory depth
    logic [FW_W-1:0] w;
    logic [FH_W-1:0] h;

    always_comb
    begin
        if (frame_width_reg == '0)
        begin
            w = FW_W'(1);
        end
        else if (frame_width_reg > FW_W'(W_CAP))
        begin
            w = FW_W'(W_CAP);
        end
        else
        begin
            w = frame_width_reg;
        end
        h = (frame_height_reg == '0) ? FH_W'(1) : frame_height_reg;
    end

    // ------------------------------------------------------------------ handshake
    logic s1_valid_reg;
    logic s1_primed_reg;
    logic s1_last_reg;
    logic s1_pix_reg;
    logic [FH_W-1:0] s1_row_reg;
    logic [CW-1:0]   s1_col_reg;
    logic [CW-1:0]   s1_addr_reg;
    logic res_valid_reg;
    logic pixel_out_reg;
    logic last_reg;

    logic ls_busy;
    logic out_free;
    logic s1_adv;
    logic accept;

    assign out_free  = !res_valid_reg || res_ready;
    assign s1_adv    = s1_valid_reg && (!s1_primed_reg || out_free);
    assign req_ready = !ls_busy && (!s1_valid_reg || s1_adv);
    assign accept    = req_valid && req_ready;

    // ------------------------------------------------------------------ positions
    // All position bookkeeping is data independent and happens at acceptance.
    logic [CW-1:0]   in_col_reg,  in_col_next;
    logic [IRW-1:0]  in_row_reg,  in_row_next;
    logic [CW-1:0]   out_col_reg, out_col_next;
    logic [FH_W-1:0] out_row_reg, out_row_next;

    logic [PW-1:0]         wext;
    logic [PW-1:0]         rhs;
    logic [PW-1:0]         cinc;
    logic [PW-1:0]         oinc;
    logic [2*RADIUS-1:0]   prm;
    logic                  primed;
    logic                  last;

    always_comb
    begin
        wext = PW'(w);
        // first result once row*w + col reaches RADIUS*w + RADIUS
        rhs  = wext * PW'(RADIUS) + PW'(RADIUS);
        for (int m = 0; m < 2 * RADIUS; m++)
        begin
            prm[m] = (wext * PW'(m) + PW'(in_col_reg)) >= rhs;
        end
        if (in_row_reg >= IRW'(2 * RADIUS))
        begin
            primed = 1'b1;
        end
        else
        begin
            primed = prm[in_row_reg[RIW-1:0]];
        end
        last = (out_row_reg >= h - FH_W'(1)) && (PW'(out_col_reg) >= wext - PW'(1));
        cinc = PW'(in_col_reg) + PW'(1);
        oinc = PW'(out_col_reg) + PW'(1);

        in_col_next  = in_col_reg;
        in_row_next  = in_row_reg;
        out_col_next = out_col_reg;
        out_row_next = out_row_reg;
        if (accept)
        begin
            if (cinc >= wext)
            begin
                in_col_next = '0;
                in_row_next = in_row_reg + IRW'(1);
            end
            else
            begin
                in_col_next = cinc[CW-1:0];
            end
            if (primed)
            begin
                if (last)
                begin
                    in_col_next  = '0;
                    in_row_next  = '0;
                    out_col_next = '0;
                    out_row_next = '0;
                end
                else if (oinc >= wext)
                begin
                    out_col_next = '0;
                    out_row_next = out_row_reg + FH_W'(1);
                end
                else
                begin
                    out_col_next = oinc[CW-1:0];
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_col_reg  <= '0;
            in_row_reg  <= '0;
            out_col_reg <= '0;
            out_row_reg <= '0;
        end
        else
        begin
            in_col_reg  <= in_col_next;
            in_row_reg  <= in_row_next;
            out_col_reg <= out_col_next;
            out_row_reg <= out_row_next;
        end
    end

    // ------------------------------------------------------------------ stage 1
    // Holds one request while its column history comes back from memory.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            s1_primed_reg <= 1'b0;
        end
        else if (accept)
        begin
            s1_valid_reg  <= 1'b1;
            s1_primed_reg <= primed;
        end
        else if (s1_adv)
        begin
            s1_valid_reg  <= 1'b0;
            s1_primed_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_last_reg <= last;
            s1_pix_reg  <= command ? 1'b0 : pixel_in;
            s1_row_reg  <= out_row_reg;
            s1_col_reg  <= out_col_reg;
            s1_addr_reg <= in_col_reg;
        end
    end

    logic [LSW-1:0]  ls_rd_data;
    logic [SIDE-1:0] new_col;
    logic            result;

    // bit 0 oldest row, top bit the pixel just received
    assign new_col = {s1_pix_reg, ls_rd_data};

    bmf_line_store #(
        .DEPTH (MAX_WIDTH),
        .DW    (LSW)
    ) u_line_store (
        .clk     (clk),
        .rst_n   (rst_n),
        .rd_en   (accept),
        .rd_addr (in_col_reg),
        .wr_en   (s1_adv),
        .wr_addr (s1_addr_reg),
        .wr_data (new_col[SIDE-1:1]),
        .rd_data (ls_rd_data),
        .busy    (ls_busy)
    );

    bmf_kernel #(
        .RADIUS (RADIUS),
        .CW     (CW)
    ) u_kernel (
        .clk      (clk),
        .rst_n    (rst_n),
        .shift_en (s1_adv),
        .new_col  (new_col),
        .mode     (mode_reg),
        .se_mask  (se_mask_reg),
        .w        (w),
        .h        (h),
        .row      (s1_row_reg),
        .col      (s1_col_reg),
        .result   (result)
    );

    // ------------------------------------------------------------------ output
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_valid_reg <= 1'b0;
        end
        else if (s1_adv && s1_primed_reg)
        begin
            res_valid_reg <= 1'b1;
        end
        else if (res_ready)
        begin
            res_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_adv && s1_primed_reg)
        begin
            pixel_out_reg <= result;
            last_reg      <= s1_last_reg;
        end
    end

    assign res_valid     = res_valid_reg;
    assign pixel_out     = pixel_out_reg;
    assign last_of_frame = last_reg;

endmodule

`default_nettype wire

>>> hdl/bmf_line_store.sv
// Column history memory: 2*RADIUS rows per column, registered read,
// write-to-read forwarding and a zeroing sweep after reset. Uses bmf_pkg nothing.
`default_nettype none

module bmf_line_store #(
    parameter int DEPTH = 1024,
    parameter int DW    = 4
) (
    input  wire logic                     clk,
    input  wire logic                     rst_n,
    input  wire logic                     rd_en,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [DW-1:0]            wr_data,
    output logic      [DW-1:0]            rd_data,
    output logic                          busy
);

    localparam int AW = $clog2(DEPTH);

    logic [DW-1:0] mem [DEPTH];
    logic [DW-1:0] mem_q_reg;
    logic [DW-1:0] fwd_data_reg;
    logic          fwd_reg;
    logic          clr_active_reg;
    logic [AW-1:0] clr_addr_reg;

    logic          we;
    logic [AW-1:0] wa;
    logic [DW-1:0] wd;

    always_comb
    begin
        we = clr_active_reg | wr_en;
        wa = clr_active_reg ? clr_addr_reg : wr_addr;
        wd = clr_active_reg ? '0 : wr_data;
    end

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[wa] <= wd;
        end
        if (rd_en)
        begin
            mem_q_reg    <= mem[rd_addr];
            fwd_data_reg <= wr_data;
        end
    end

    // same-edge write to the address being read: take the new data
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fwd_reg        <= 1'b0;
            clr_active_reg <= 1'b1;
            clr_addr_reg   <= '0;
        end
        else
        begin
            if (rd_en)
            begin
                fwd_reg <= wr_en && (wr_addr == rd_addr);
            end
            if (clr_active_reg)
            begin
                if (clr_addr_reg == AW'(DEPTH - 1))
                begin
                    clr_active_reg <= 1'b0;
                end
                clr_addr_reg <= clr_addr_reg + AW'(1);
            end
        end
    end

    assign rd_data = fwd_reg ? fwd_data_reg : mem_q_reg;
    assign busy    = clr_active_reg;

endmodule

`default_nettype wire

>>> hdl/bmf_kernel.sv
// Window register and erosion/dilation decision for one output position.
// Depends on bmf_pkg (widths, mode codes).
`default_nettype none

module bmf_kernel #(
    parameter int RADIUS = 2,
    parameter int CW     = 10
) (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       shift_en,
    input  wire logic [2*RADIUS:0]          new_col,
    input  wire logic                       mode,
    input  wire logic [bmf_pkg::MASK_W-1:0] se_mask,
    input  wire logic [bmf_pkg::FW_W-1:0]   w,
    input  wire logic [bmf_pkg::FH_W-1:0]   h,
    input  wire logic [bmf_pkg::FH_W-1:0]   row,
    input  wire logic [CW-1:0]              col,
    output logic                            result
);

    localparam int SIDE = 2 * RADIUS + 1;
    localparam int WIN  = SIDE * SIDE;
    localparam int RW   = bmf_pkg::FH_W + 2;
    localparam int CX   = ((bmf_pkg::FW_W > CW) ? bmf_pkg::FW_W : CW) + 2;

    logic [WIN-1:0]  window_reg;
    logic [WIN-1:0]  window_next;
    logic [SIDE-1:0] row_ok;
    logic [SIDE-1:0] col_ok;
    logic [WIN-1:0]  sel;
    logic [WIN-1:0]  hit;
    logic            center;

    // oldest column in the low bits, newest column enters at the top
    assign window_next = (window_reg >> SIDE) | {new_col, {(WIN - SIDE){1'b0}}};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            window_reg <= '0;
        end
        else if (shift_en)
        begin
            window_reg <= window_next;
        end
    end

    // frame bounds per row / column offset; index i stands for offset i-RADIUS
    always_comb
    begin
        for (int i = 0; i < SIDE; i++)
        begin
            row_ok[i] = (RW'(row) + RW'(i) >= RW'(RADIUS)) &&
                        (RW'(row) + RW'(i) <  RW'(h) + RW'(RADIUS));
            col_ok[i] = (CX'(col) + CX'(i) >= CX'(RADIUS)) &&
                        (CX'(col) + CX'(i) <  CX'(w) + CX'(RADIUS));
        end
    end

    // i: row offset index, j: column offset index. Dilation uses the reflected mask.
    for (genvar i = 0; i < SIDE; i++)
    begin : g_row
        for (genvar j = 0; j < SIDE; j++)
        begin : g_col
            localparam int KE = i * SIDE + j;
            localparam int KD = (SIDE - 1 - i) * SIDE + (SIDE - 1 - j);
            logic me;
            logic md;
            if (KE < bmf_pkg::MASK_W)
            begin : g_me
                assign me = se_mask[KE];
            end
            else
            begin : g_me0
                assign me = 1'b0;
            end
            if (KD < bmf_pkg::MASK_W)
            begin : g_md
                assign md = se_mask[KD];
            end
            else
            begin : g_md0
                assign md = 1'b0;
            end
            assign sel[KE] = (mode == bmf_pkg::MODE_DILATE) ? md : me;
            assign hit[KE] = row_ok[i] & col_ok[j] & window_next[j * SIDE + i];
        end
    end

    assign center = window_next[RADIUS * SIDE + RADIUS];

    always_comb
    begin
        case (mode)
            bmf_pkg::MODE_ERODE:  result = center & (&(~sel | hit));
            bmf_pkg::MODE_DILATE: result = center | (|(sel & hit));
            default:              result = 1'b0;
        endcase
    end

endmodule

`default_nettype wire

>>> tb/sv/tb_binary_morphology_filter.sv
// Testbench for binary_morphology_filter: streams binary frames through the
// erosion/dilation filter and checks every filtered pixel against a predictor.
// Depends on bmf_pkg and the binary_morphology_filter RTL.
`timescale 1ns / 1ps

module tb_binary_morphology_filter;

    // Geometry of the filter as built (default parameters)
    localparam int RAD  = bmf_pkg::RADIUS_DEF;
    localparam int SIDE = 2 * RAD + 1;
    localparam int MAXW = bmf_pkg::MAX_WIDTH_DEF;

    // Request command codes
    localparam logic CMD_PIXEL = 1'b0;
    localparam logic CMD_DRAIN = 1'b1;

    // Short names for the mode codes, used by the directed table
    localparam logic ERODE  = bmf_pkg::MODE_ERODE;
    localparam logic DILATE = bmf_pkg::MODE_DILATE;

    // Structuring elements used by the stimulus
    localparam logic [bmf_pkg::MASK_W-1:0] MASK_NONE   = '0;
    localparam logic [bmf_pkg::MASK_W-1:0] MASK_ALL    = '1;
    localparam logic [bmf_pkg::MASK_W-1:0] MASK_CENTER = 25'h0001000;
    localparam logic [bmf_pkg::MASK_W-1:0] MASK_CROSS  = 25'h0023880;
    localparam logic [bmf_pkg::MASK_W-1:0] MASK_SQUARE = bmf_pkg::MASK_RESET;

    localparam int HALF_PERIOD = 6;
    localparam int RESET_CYCLES = 7;
    localparam int IDLE_PCT = 38;
    localparam int SETTLE_CYCLES = 4;   // result register plus internal stage, with margin
    localparam int HOLD_CYCLES = 250;   // long receiver hold-off
    localparam int QUIET_LIMIT = 4000;  // covers the reset sweep of all MAXW column entries
    localparam int RANDOM_REQUESTS = 800;
    localparam int LAST_PHASE = 7;      // every phase below this one runs at least once

    typedef struct packed {
        logic pix;
        logic lst;
    } filt_res_t;

    // One directed row: optional register setup, one request, optional typed expectation
    typedef struct packed {
        logic                       cfg;
        logic                       mode;
        logic [bmf_pkg::MASK_W-1:0] mask;
        logic [bmf_pkg::FW_W-1:0]   w;
        logic [bmf_pkg::FH_W-1:0]   h;
        logic                       cmd;
        logic                       pix;
        logic                       typed;
        logic                       res;
        logic                       exp_pix;
        logic                       exp_last;
    } dir_row_t;

    localparam int DIR_ROWS = 20;

    // Four 1x1 frames, five requests each (one pixel position plus RADIUS*1+RADIUS tail requests).
    dir_row_t dir_tab [0:DIR_ROWS-1] = '{
        // erosion, center-only mask: a lone object pixel survives
        '{1'b1, ERODE, MASK_CENTER, 11'd1, 12'd1, CMD_PIXEL, 1'b1, 1'b1, 1'b0, 1'b0, 1'b0},
        '{1'b0, ERODE, MASK_CENTER, 11'd1, 12'd1, CMD_DRAIN, 1'b0, 1'b1, 1'b0, 1'b0, 1'b0},
        '{1'b0, ERODE, MASK_CENTER, 11'd1, 12'd1, CMD_DRAIN, 1'b0, 1'b1, 1'b0, 1'b0, 1'b0},
        '{1'b0, ERODE, MASK_CENTER, 11'd1, 12'd1, CMD_DRAIN, 1'b0, 1'b1, 1'b0, 1'b0, 1'b0},
        '{1'b0, ERODE, MASK_CENTER, 11'd1, 12'd1, CMD_DRAIN, 1'b1, 1'b1, 1'b1, 1'b1, 1'b1},
        // erosion, full mask, zero width/height act as 1: frame edge kills the pixel
        '{1'b1, ERODE, MASK_ALL, 11'd0, 12'd0, CMD_PIXEL, 1'b1, 1'b1, 1'b0, 1'b0, 1'b0},
        '{1'b0, ERODE, MASK_ALL, 11'd0, 12'd0, CMD_DRAIN, 1'b1, 1'b1, 1'b0, 1'b0, 1'b0},
        '{1'b0, ERODE, MASK_ALL, 11'd0, 12'd0, CMD_DRAIN, 1'b0, 1'b1, 1'b0, 1'b0, 1'b0},
        '{1'b0, ERODE, MASK_ALL, 11'd0, 12'd0, CMD_DRAIN, 1'b1, 1'b1, 1'b0, 1'b0, 1'b0},
        '{1'b0, ERODE, MASK_ALL, 11'd0, 12'd0, CMD_DRAIN, 1'b0, 1'b1, 1'b1, 1'b0, 1'b1},
        // dilation, empty mask, drain in place of the pixel (pixel bit must be ignored)
        '{1'b1, DILATE, MASK_NONE, 11'd1, 12'd1, CMD_DRAIN, 1'b1, 1'b0, 1'b0, 1'b0, 1'b0},
        '{1'b0, DILATE, MASK_NONE, 11'd1, 12'd1, CMD_DRAIN, 1'b1, 1'b0, 1'b0, 1'b0, 1'b0},
        '{1'b0, DILATE, MASK_NONE, 11'd1, 12'd1, CMD_DRAIN, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0},
        '{1'b0, DILATE, MASK_NONE, 11'd1, 12'd1, CMD_DRAIN, 1'b1, 1'b0, 1'b0, 1'b0, 1'b0},
        '{1'b0, DILATE, MASK_NONE, 11'd1, 12'd1, CMD_DRAIN, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0},
        // dilation, full mask, object pixels past the last row stay outside the frame
        '{1'b1, DILATE, MASK_ALL, 11'd1, 12'd1, CMD_PIXEL, 1'b0, 1'b1, 1'b0, 1'b0, 1'b0},
        '{1'b0, DILATE, MASK_ALL, 11'd1, 12'd1, CMD_PIXEL, 1'b1, 1'b1, 1'b0, 1'b0, 1'b0},
        '{1'b0, DILATE, MASK_ALL, 11'd1, 12'd1, CMD_PIXEL, 1'b1, 1'b1, 1'b0, 1'b0, 1'b0},
        '{1'b0, DILATE, MASK_ALL, 11'd1, 12'd1, CMD_PIXEL, 1'b1, 1'b1, 1'b0, 1'b0, 1'b0},
        '{1'b0, DILATE, MASK_ALL, 11'd1, 12'd1, CMD_PIXEL, 1'b1, 1'b1, 1'b1, 1'b0, 1'b1}
    };

    // DUT connections; every input starts at a known value
    logic                        clk = 1'b0;
    logic                        rst_n = 1'b0;
    logic                        psel = 1'b0;
    logic                        penable = 1'b0;
    logic                        pwrite = 1'b0;
    logic [bmf_pkg::PADDR_W-1:0] paddr = '0;
    logic [bmf_pkg::DATA_W-1:0]  pwdata = '0;
    logic [bmf_pkg::DATA_W-1:0]  prdata;
    logic                        pready;
    logic                        req_valid = 1'b0;
    logic                        req_ready;
    logic                        command = 1'b0;
    logic                        pixel_in = 1'b0;
    logic                        res_valid;
    logic                        res_ready = 1'b0;
    logic                        pixel_out;
    logic                        last_of_frame;

    // Predictor state: register shadows plus the window/line history
    logic                       cfg_mode = bmf_pkg::MODE_ERODE;
    logic [bmf_pkg::MASK_W-1:0] cfg_mask = bmf_pkg::MASK_RESET;
    logic [bmf_pkg::FW_W-1:0]   cfg_w = bmf_pkg::WIDTH_RESET;
    logic [bmf_pkg::FH_W-1:0]   cfg_h = bmf_pkg::HEIGHT_RESET;
    logic [2*RAD-1:0]  col_hist [MAXW];
    logic [SIDE*SIDE-1:0] win_bits = '0;
    int in_col = 0;
    int in_row = 0;
    int out_col = 0;
    int out_row = 0;

    filt_res_t filtered_q [$];
    int mismatches = 0;
    int results_seen = 0;
    int rand_requests = 0;
    int quiet_cycles = 0;
    int hold_left = 0;
    int hold_asked = 0;    // bumped by the sender side to ask for a hold-off
    int hold_taken = 0;    // hold-off requests already started by the receiver side
    bit idle_on = 1'b1;

    binary_morphology_filter u_top (
        .clk           (clk),
        .rst_n         (rst_n),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready),
        .req_valid     (req_valid),
        .req_ready     (req_ready),
        .command       (command),
        .pixel_in      (pixel_in),
        .res_valid     (res_valid),
        .res_ready     (res_ready),
        .pixel_out     (pixel_out),
        .last_of_frame (last_of_frame)
    );

    always #HALF_PERIOD clk = ~clk;

    // ------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------

    // Out-of-range sizes: 0 acts as 1, width clamps at MAXW
    function automatic int eff_width();
        return (cfg_w == 0) ? 1 : ((cfg_w > MAXW) ? MAXW : int'(cfg_w));
    endfunction

    function automatic int eff_height();
        return (cfg_h == 0) ? 1 : int'(cfg_h);
    endfunction

    // Column groups run oldest to newest from bit 0; within a group bit 0 is the
    // oldest row. Offset (0,0) is the pixel being filtered.
    function automatic logic win_at(int dr, int dc);
        return win_bits[(RAD + dc) * SIDE + (RAD + dr)];
    endfunction

    function automatic logic in_frame(int r, int c, int w, int h);
        return r >= 0 && r < h && c >= 0 && c < w;
    endfunction

    // Advances the filter by one request; returns 1 when a filtered pixel is due.
    function automatic logic morph_step(input logic cmd, input logic pix_v,
                                        output filt_res_t res);
        int w;
        int h;
        int col;
        int k;
        longint pos;
        logic px;
        logic hit;
        logic [SIDE-1:0] newcol;
        w = eff_width();
        h = eff_height();
        px = (cmd == CMD_DRAIN) ? 1'b0 : pix_v;   // drain = background pixel
        col = (in_col < MAXW) ? in_col : MAXW - 1;
        newcol = {px, col_hist[col]};
        col_hist[col] = newcol[SIDE-1:1];
        win_bits = {newcol, win_bits[SIDE*SIDE-1:SIDE]};
        pos = longint'(in_row) * w + in_col;
        in_col++;
        if (in_col >= w)
        begin
            in_col = 0;
            in_row++;
        end
        res = '0;
        if (pos < longint'(RAD) * w + RAD)
            return 1'b0;

        hit = win_at(0, 0);
        for (int dr = -RAD; dr <= RAD; dr++)
        begin
            for (int dc = -RAD; dc <= RAD; dc++)
            begin
                k = (dr + RAD) * SIDE + (dc + RAD);
                if (!cfg_mask[k])
                    continue;
                if (cfg_mode == bmf_pkg::MODE_ERODE)
                begin
                    // frame edge counts as background
                    if (!(in_frame(out_row + dr, out_col + dc, w, h) && win_at(dr, dc)))
                        hit = 1'b0;
                end
                else if (in_frame(out_row - dr, out_col - dc, w, h) && win_at(-dr, -dc))
                    hit = 1'b1;
            end
        end
        res.pix = hit;
        res.lst = (out_row >= h - 1) && (out_col >= w - 1);

        if (res.lst)
        begin
            // frame done: all positions restart, history is kept
            in_col = 0;
            in_row = 0;
            out_col = 0;
            out_row = 0;
        end
        else
        begin
            out_col++;
            if (out_col >= w)
            begin
                out_col = 0;
                out_row++;
            end
        end
        return 1'b1;
    endfunction

    // Appends one expected filtered pixel at the tail of the queue
    function automatic void queue_expected(filt_res_t r);
        filtered_q = {filtered_q, r};
    endfunction

    // ------------------------------------------------------------------
    // Checking
    // ------------------------------------------------------------------

    task automatic flag_mismatch(string what, int got, int want);
        $display("MISMATCH %s: got %0d expected %0d (result %0d, t=%0t)",
                 what, got, want, results_seen, $realtime);
        mismatches++;
    endtask

    always @(posedge clk)
    begin : result_check
        filt_res_t want;
        if (rst_n && res_valid && res_ready)
        begin
            if (filtered_q.size() == 0)
                flag_mismatch("result with nothing pending", int'(pixel_out), 0);
            else
            begin
                want = filtered_q.pop_front();
                if (pixel_out !== want.pix)
                    flag_mismatch("pixel_out", int'(pixel_out), int'(want.pix));
                if (last_of_frame !== want.lst)
                    flag_mismatch("last_of_frame", int'(last_of_frame), int'(want.lst));
            end
            results_seen++;
        end
    end

    // Watchdog: too long without any request or result moving ends the run
    always @(posedge clk)
    begin
        if ((req_valid && req_ready) || (res_valid && res_ready))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= QUIET_LIMIT)
        begin
            $display("tb: failure");
            $finish;
        end
    end

    // Result side: random back-pressure, or a long hold-off when asked.
    // The hold-off is counted here so the sender keeps pushing meanwhile.
    always @(negedge clk)
    begin
        if (hold_asked != hold_taken)
        begin
            hold_taken = hold_asked;
            hold_left = HOLD_CYCLES;
        end
        if (hold_left > 0)
        begin
            hold_left--;
            res_ready <= 1'b0;
        end
        else
            res_ready <= !(idle_on && $urandom_range(99) < IDLE_PCT);
    end

    // ------------------------------------------------------------------
    // Configuration port
    // ------------------------------------------------------------------

    // Random junk above the register width; the block must ignore it
    function automatic logic [bmf_pkg::DATA_W-1:0] with_noise(
            logic [bmf_pkg::DATA_W-1:0] v, int wd);
        logic [bmf_pkg::DATA_W-1:0] m;
        m = (32'd1 << wd) - 32'd1;
        return ($urandom & ~m) | (v & m);
    endfunction

    // Called at a falling edge; returns at a falling edge with the bus idle
    task automatic apb_write(logic [1:0] idx, logic [bmf_pkg::DATA_W-1:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= data;
        @(negedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        case (idx)
            bmf_pkg::REG_MODE:   cfg_mode = data[0];
            bmf_pkg::REG_MASK:   cfg_mask = data[bmf_pkg::MASK_W-1:0];
            bmf_pkg::REG_WIDTH:  cfg_w    = data[bmf_pkg::FW_W-1:0];
            bmf_pkg::REG_HEIGHT: cfg_h    = data[bmf_pkg::FH_W-1:0];
            default:             ;
        endcase
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        @(negedge clk);
    endtask

    task automatic check_reg(logic [1:0] idx, logic [bmf_pkg::DATA_W-1:0] want, int wd);
        logic [bmf_pkg::DATA_W-1:0] m;
        m = (32'd1 << wd) - 32'd1;
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= {idx, 2'b00};
        @(negedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        if ((prdata & m) !== want)
            flag_mismatch("register readback", int'(prdata & m), int'(want));
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        @(negedge clk);
    endtask

    // ------------------------------------------------------------------
    // Request side
    // ------------------------------------------------------------------

    // Drop valid and wait until every filtered pixel is back
    task automatic wait_drained();
        req_valid <= 1'b0;
        do @(negedge clk); while (filtered_q.size() != 0);
    endtask

    // Registers change only between frames, with the pipeline empty
    task automatic set_config(logic m, logic [bmf_pkg::MASK_W-1:0] mask, int w, int h);
        wait_drained();
        repeat (SETTLE_CYCLES) @(negedge clk);
        apb_write(bmf_pkg::REG_MODE, with_noise(bmf_pkg::DATA_W'(m), 1));
        apb_write(bmf_pkg::REG_MASK, with_noise(bmf_pkg::DATA_W'(mask), bmf_pkg::MASK_W));
        apb_write(bmf_pkg::REG_WIDTH, with_noise(w, bmf_pkg::FW_W));
        apb_write(bmf_pkg::REG_HEIGHT, with_noise(h, bmf_pkg::FH_W));
    endtask

    // One request. Entered at a falling edge, returns at the falling edge after
    // acceptance. Valid is left high so the next request can follow directly.
    task automatic send_item(logic c, logic px, logic typed, logic t_res,
                             logic t_pix, logic t_last);
        filt_res_t pred;
        logic due;
        while (idle_on && $urandom_range(99) < IDLE_PCT)
        begin
            req_valid <= 1'b0;
            @(negedge clk);
        end
        req_valid <= 1'b1;
        command   <= c;
        pixel_in  <= px;
        do @(posedge clk); while (!req_ready);
        due = morph_step(c, px, pred);
        if (typed)
        begin
            pred.pix = t_pix;
            pred.lst = t_last;
            due = t_res;
        end
        if (due)
            queue_expected(pred);
        @(negedge clk);
    endtask

    // Whole frame: w*h pixels then the drain tail. A few drains land inside the
    // frame and a few pixels land in the tail (past the last row).
    task automatic send_frame(bit pause_mid);
        int w;
        int h;
        int n_pix;
        int total;
        int dens;
        int pause_at;
        logic c;
        w = eff_width();
        h = eff_height();
        n_pix = w * h;
        total = n_pix + RAD * w + RAD;
        dens = $urandom_range(95, 20);
        pause_at = pause_mid ? $urandom_range(total - 1) : -1;
        for (int i = 0; i < total; i++)
        begin
            if (i == pause_at)
                wait_drained();
            if (i < n_pix)
                c = ($urandom_range(99) < 4) ? CMD_DRAIN : CMD_PIXEL;
            else
                c = ($urandom_range(99) < 85) ? CMD_DRAIN : CMD_PIXEL;
            send_item(c, $urandom_range(99) < dens, 1'b0, 1'b0, 1'b0, 1'b0);
            rand_requests++;
        end
    endtask

    function automatic logic [bmf_pkg::MASK_W-1:0] pick_mask();
        case ($urandom_range(6))
            0:       return bmf_pkg::MASK_W'($urandom);
            1:       return bmf_pkg::MASK_W'($urandom & $urandom & $urandom);  // sparse
            2:       return MASK_SQUARE;
            3:       return MASK_CROSS;
            4:       return MASK_CENTER;
            5:       return MASK_NONE;
            default: return MASK_ALL;
        endcase
    endfunction

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------
    initial
    begin
        dir_row_t row;
        int p;
        int w;
        int h;

        foreach (col_hist[i])
            col_hist[i] = '0;

        repeat (RESET_CYCLES) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Reset values; the block is still sweeping its column memory here
        check_reg(bmf_pkg::REG_MODE, bmf_pkg::DATA_W'(bmf_pkg::MODE_ERODE), 1);
        check_reg(bmf_pkg::REG_MASK, bmf_pkg::DATA_W'(bmf_pkg::MASK_RESET), bmf_pkg::MASK_W);
        check_reg(bmf_pkg::REG_WIDTH, bmf_pkg::DATA_W'(bmf_pkg::WIDTH_RESET), bmf_pkg::FW_W);
        check_reg(bmf_pkg::REG_HEIGHT, bmf_pkg::DATA_W'(bmf_pkg::HEIGHT_RESET),
                  bmf_pkg::FH_W);

        // Directed 1x1 frames
        for (int i = 0; i < DIR_ROWS; i++)
        begin
            row = dir_tab[i];
            if (row.cfg)
                set_config(row.mode, row.mask, row.w, row.h);
            send_item(row.cmd, row.pix, row.typed, row.res, row.exp_pix, row.exp_last);
        end

        // Random frames, small sizes. Phase 2 holds the result side off for a long
        // stretch so the block fills and stalls requests; phases 4-6 run with no
        // idling on either side; phase 5 pauses mid-frame until all results are in.
        p = 0;
        while (p < LAST_PHASE || rand_requests < RANDOM_REQUESTS)
        begin
            idle_on = !(p >= 4 && p <= 6);
            w = $urandom_range(12, 1);
            h = $urandom_range(10, 1);
            if (p == 2)
            begin
                w = 24;
                h = 6;
            end
            set_config(1'($urandom_range(1)), pick_mask(), w, h);
            if (p == 2)
                hold_asked++;
            repeat ((p == 2) ? 1 : $urandom_range(3, 1))
                send_frame(p == 5);
            p++;
        end

        wait_drained();
        repeat (2 * SETTLE_CYCLES) @(negedge clk);
        if (mismatches == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule

>>> files.f
hdl/bmf_pkg.sv
hdl/bmf_line_store.sv
hdl/bmf_kernel.sv
hdl/binary_morphology_filter.sv
tb/sv/tb_binary_morphology_filter.sv
